// ===== design/ground_pixel_to_scan_bins_macros.svh =====
// assertion helpers for the scan bin block
`ifndef GROUND_PIXEL_TO_SCAN_BINS_MACROS_SVH
`define GROUND_PIXEL_TO_SCAN_BINS_MACROS_SVH
`ifndef SYNTHESIS
`define GPSB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GPSB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GPSB_ASSERT_IMP(lbl, ante, cons)
`define GPSB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/gpsb_pkg.sv =====
package gpsb_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 30;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_UNMARKED = 3'd1;
  localparam logic [2:0] ST_CLOSE    = 3'd2;
  localparam logic [2:0] ST_ANGLE    = 3'd3;
  localparam logic [2:0] ST_ORIGIN   = 3'd4;

  localparam logic [2:0] REG_FORWARD_OFFSET = 3'd0;
  localparam logic [2:0] REG_ROW_STEP       = 3'd1;
  localparam logic [2:0] REG_COL_STEP       = 3'd2;
  localparam logic [2:0] REG_IMAGE_ROWS     = 3'd3;
  localparam logic [2:0] REG_IMAGE_COLS     = 3'd4;
  localparam logic [2:0] REG_MIN_RANGE      = 3'd5;
  localparam logic [2:0] REG_MAX_RANGE      = 3'd6;

  localparam logic [23:0] RST_FORWARD_OFFSET = 24'd45985;
  localparam logic [23:0] RST_ROW_STEP       = 24'd92039;
  localparam logic [23:0] RST_COL_STEP       = 24'd104975;
  localparam logic [11:0] RST_IMAGE_ROWS     = 12'd768;
  localparam logic [11:0] RST_IMAGE_COLS     = 12'd1024;
  localparam logic [23:0] RST_MIN_RANGE      = 24'd29491;
  localparam logic [23:0] RST_MAX_RANGE      = 24'd655360;

  localparam logic [24:0] ONE_METRE = 25'd65536;
  localparam logic [24:0] RANGE_SAT = 25'h1FFFFFF;
  localparam logic [7:0]  PIX_MARK  = 8'd255;

  typedef struct packed {
    logic [1:0]  action;
    logic [10:0] row;
    logic [10:0] col;
    logic [7:0]  pixel_value;
    logic [9:0]  read_bin;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  bin;
    logic [24:0] range;
    logic        updated;
  } out_t;

  function automatic logic [23:0] arc_angle(input logic [4:0] i);
    logic [23:0] v;
    case (i)
      5'd0:  v = 24'd8388608;
      5'd1:  v = 24'd4952084;
      5'd2:  v = 24'd2616545;
      5'd3:  v = 24'd1328199;
      5'd4:  v = 24'd666677;
      5'd5:  v = 24'd333664;
      5'd6:  v = 24'd166872;
      5'd7:  v = 24'd83441;
      5'd8:  v = 24'd41721;
      5'd9:  v = 24'd20861;
      5'd10: v = 24'd10430;
      5'd11: v = 24'd5215;
      5'd12: v = 24'd2608;
      5'd13: v = 24'd1304;
      5'd14: v = 24'd652;
      5'd15: v = 24'd326;
      5'd16: v = 24'd163;
      5'd17: v = 24'd81;
      5'd18: v = 24'd41;
      5'd19: v = 24'd20;
      5'd20: v = 24'd10;
      5'd21: v = 24'd5;
      5'd22: v = 24'd3;
      5'd23: v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/gpsb_mul.sv =====
module gpsb_mul (
  input  logic               clk,
  input  logic signed [29:0] op_a,
  input  logic signed [29:0] op_b,
  output logic signed [59:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// ===== design/gpsb_isqrt.sv =====
module gpsb_isqrt (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [59:0] value,
  output logic [29:0] root
);

  logic [59:0] rem;
  logic [59:0] res;
  logic [59:0] bitv;
  logic [59:0] trial;

  assign trial = res + bitv;
  assign root  = res[29:0];

  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= value;
      res  <= '0;
      bitv <= 60'(1) << 58;
    end else if (step) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ===== design/gpsb_cordic.sv =====
module gpsb_cordic (
  input  logic               clk,
  input  logic               load,
  input  logic               step,
  input  logic [4:0]         idx,
  input  logic signed [39:0] x0,
  input  logic signed [39:0] y0,
  output logic signed [26:0] z
);

  logic signed [41:0] x;
  logic signed [41:0] y;
  logic signed [41:0] dx;
  logic signed [41:0] dy;
  logic signed [26:0] arc;

  assign dx  = y >>> idx;
  assign dy  = x >>> idx;
  assign arc = $signed({3'b000, gpsb_pkg::arc_angle(idx)});

  always_ff @(posedge clk) begin
    if (load) begin
      x <= 42'(x0);
      y <= 42'(y0);
      z <= '0;
    end else if (step) begin
      if (!y[41]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + arc;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - arc;
      end
    end
  end

endmodule

// ===== design/gpsb_bin_mem.sv =====
module gpsb_bin_mem #(
  parameter int DEPTH = 360,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [24:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [24:0]   rdata
);

  logic [24:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ground_pixel_to_scan_bins.sv =====
// ground pixel to scan bins
// in_valid/in_ready take one word: a clear, a pixel or a bin read.
// out_valid/out_ready return exactly one result word per input word.
// cfg_we/cfg_index/cfg_data write a register at once; write only while idle.
// one word is worked on at a time; in_ready is high only when idle.
// a marked pixel off the origin makes four passes through the shared
// 30x30 multiplier and runs the bit-serial square root alongside the
// 24-step angle rotation; one neither too close nor behind then takes
// one more multiply for the bin where needed, then a read-modify-write
// of the bin memory. unmarked pixels and unused actions go straight to
// their result, bin reads through a read of the bin memory. a clear
// sweeps the bin memory one entry a cycle; after reset the same sweep
// runs with in_ready low, filling every bin with max_range plus one metre.
// a finished result sits in the output register until taken; while the
// receiver stalls the block holds the next result and takes no new word.
`include "ground_pixel_to_scan_bins_macros.svh"
module ground_pixel_to_scan_bins #(
  parameter int NUM_BINS = 360,
  parameter int MAX_DIM  = 2048
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gpsb_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gpsb_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [23:0]     cfg_data
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  typedef enum logic [14:0] {
    S_SWEEP = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_MUL_F = 15'b000000000000100,
    S_MUL_S = 15'b000000000001000,
    S_CHK   = 15'b000000000010000,
    S_MUL_A = 15'b000000000100000,
    S_MUL_B = 15'b000000001000000,
    S_SUM   = 15'b000000010000000,
    S_ITER  = 15'b000000100000000,
    S_EVAL  = 15'b000001000000000,
    S_MUL_T = 15'b000010000000000,
    S_BIN   = 15'b000100000000000,
    S_RD    = 15'b001000000000000,
    S_UPD   = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  state_t state;

  logic [23:0] forward_offset;
  logic [23:0] row_step;
  logic [23:0] col_step;
  logic [11:0] image_rows;
  logic [11:0] image_cols;
  logic [23:0] min_range;
  logic [23:0] max_range;

  gpsb_pkg::in_t  item;
  gpsb_pkg::out_t res;

  logic signed [39:0] f;
  logic signed [39:0] s;
  logic [28:0]        a;
  logic [28:0]        b;
  logic               big;
  logic [59:0]        sq;
  logic [4:0]         cnt;
  logic [9:0]         bin_r;
  logic [24:0]        r16;
  logic [24:0]        fill;
  logic [AW-1:0]      sweep_cnt;
  logic               sweep_item;

  logic signed [29:0] op_a;
  logic signed [29:0] op_b;
  logic signed [59:0] prod;
  logic [29:0]        root;
  logic signed [26:0] z;
  logic [24:0]        rd_data;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [24:0]        mem_wdata;

  logic signed [12:0] diff_r;
  logic signed [12:0] diff_c;
  logic signed [39:0] s_w;
  logic [39:0]        ma;
  logic [39:0]        mb;
  logic [30:0]        rsum;
  logic [26:0]        r_raw;
  logic [24:0]        r16_w;
  logic               close;
  logic signed [26:0] t;
  logic [15:0]        bq;
  logic [24:0]        fill_w;
  logic [12:0]        dim_w;
  logic [11:0]        dim_clamped;

  assign in_ready = (state == S_IDLE);

  assign diff_r = $signed({1'b0, image_rows}) - $signed({2'b00, item.row});
  assign diff_c = $signed({2'b00, image_cols[11:1]}) - $signed({2'b00, item.col});
  assign s_w    = $signed(prod[39:0]);
  assign ma     = f[39] ? 40'(-f) : 40'(f);
  assign mb     = s_w[39] ? 40'(-s_w) : 40'(s_w);
  assign rsum   = {1'b0, root} + 31'd8;
  assign r_raw  = rsum[30:4];
  assign r16_w  = big ? gpsb_pkg::RANGE_SAT :
                  ((r_raw > 27'(gpsb_pkg::RANGE_SAT)) ? gpsb_pkg::RANGE_SAT : r_raw[24:0]);
  assign close  = !big && (root < {2'b00, min_range, 4'b0000});
  assign t      = z + 27'sd16777216;
  assign bq     = prod[40:25];
  assign fill_w = {1'b0, max_range} + gpsb_pkg::ONE_METRE;
  assign dim_w  = {1'b0, cfg_data[11:0]};
  assign dim_clamped = (dim_w > 13'(MAX_DIM)) ? 12'(MAX_DIM) : cfg_data[11:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_MUL_F: begin
        op_a = 30'(diff_r);
        op_b = $signed({6'b0, row_step});
      end
      S_MUL_S: begin
        op_a = 30'(diff_c);
        op_b = $signed({6'b0, col_step});
      end
      S_MUL_A: begin
        op_a = $signed({1'b0, a});
        op_b = $signed({1'b0, a});
      end
      S_MUL_B: begin
        op_a = $signed({1'b0, b});
        op_b = $signed({1'b0, b});
      end
      S_MUL_T: begin
        op_a = 30'(t);
        op_b = 30'(NUM_BINS);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bin_r[AW-1:0];
    mem_wdata = r16;
    if (state == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_cnt;
      mem_wdata = fill;
    end else if (state == S_UPD && item.action == gpsb_pkg::ACT_PIXEL && rd_data > r16) begin
      mem_we = 1'b1;
    end
  end

  gpsb_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  gpsb_isqrt u_isqrt (
    .clk   (clk),
    .load  (state == S_SUM),
    .step  (state == S_ITER),
    .value (sq + $unsigned(prod)),
    .root  (root)
  );

  gpsb_cordic u_cordic (
    .clk  (clk),
    .load (state == S_SUM),
    .step (state == S_ITER && cnt < 5'(gpsb_pkg::CORDIC_STEPS)),
    .idx  (cnt),
    .x0   (f),
    .y0   (s),
    .z    (z)
  );

  gpsb_bin_mem #(
    .DEPTH (NUM_BINS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (bin_r[AW-1:0]),
    .rdata (rd_data)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      forward_offset <= gpsb_pkg::RST_FORWARD_OFFSET;
      row_step       <= gpsb_pkg::RST_ROW_STEP;
      col_step       <= gpsb_pkg::RST_COL_STEP;
      image_rows     <= gpsb_pkg::RST_IMAGE_ROWS;
      image_cols     <= gpsb_pkg::RST_IMAGE_COLS;
      min_range      <= gpsb_pkg::RST_MIN_RANGE;
      max_range      <= gpsb_pkg::RST_MAX_RANGE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gpsb_pkg::REG_FORWARD_OFFSET: forward_offset <= cfg_data;
        gpsb_pkg::REG_ROW_STEP:       row_step       <= cfg_data;
        gpsb_pkg::REG_COL_STEP:       col_step       <= cfg_data;
        gpsb_pkg::REG_IMAGE_ROWS:     image_rows     <= dim_clamped;
        gpsb_pkg::REG_IMAGE_COLS:     image_cols     <= dim_clamped;
        gpsb_pkg::REG_MIN_RANGE:      min_range      <= cfg_data;
        gpsb_pkg::REG_MAX_RANGE:      max_range      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_cnt  <= '0;
      sweep_item <= 1'b0;
      fill       <= {1'b0, gpsb_pkg::RST_MAX_RANGE} + gpsb_pkg::ONE_METRE;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          if (sweep_cnt == AW'(NUM_BINS - 1)) begin
            sweep_cnt <= '0;
            state     <= sweep_item ? S_DONE : S_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            unique case (in_data.action)
              gpsb_pkg::ACT_CLEAR: begin
                fill       <= fill_w;
                res        <= {gpsb_pkg::ST_DONE, 10'd0, fill_w, 1'b0};
                sweep_item <= 1'b1;
                sweep_cnt  <= '0;
                state      <= S_SWEEP;
              end
              gpsb_pkg::ACT_PIXEL: begin
                if (in_data.pixel_value != gpsb_pkg::PIX_MARK) begin
                  res   <= {gpsb_pkg::ST_UNMARKED, 10'd0, 25'd0, 1'b0};
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_MUL_F;
                end
              end
              gpsb_pkg::ACT_READ: begin
                res   <= '0;
                bin_r <= ({1'b0, in_data.read_bin} >= 11'(NUM_BINS)) ?
                         10'(NUM_BINS - 1) : in_data.read_bin;
                state <= S_RD;
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MUL_F: state <= S_MUL_S;
        S_MUL_S: begin
          f     <= $signed({8'b0, forward_offset, 8'b0}) + $signed(prod[39:0]);
          state <= S_CHK;
        end
        S_CHK: begin
          s   <= s_w;
          big <= (ma[39:33] != 7'd0) || (mb[39:33] != 7'd0);
          a   <= (ma[39:33] != 7'd0) || (mb[39:33] != 7'd0) ? 29'd0 : ma[32:4];
          b   <= (ma[39:33] != 7'd0) || (mb[39:33] != 7'd0) ? 29'd0 : mb[32:4];
          if (f == 40'sd0 && s_w == 40'sd0) begin
            res.status <= gpsb_pkg::ST_ORIGIN;
            state      <= S_DONE;
          end else begin
            state <= S_MUL_A;
          end
        end
        S_MUL_A: state <= S_MUL_B;
        S_MUL_B: begin
          sq    <= $unsigned(prod);
          state <= S_SUM;
        end
        S_SUM: begin
          cnt   <= '0;
          state <= S_ITER;
        end
        S_ITER: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'(gpsb_pkg::SQRT_STEPS - 1)) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          r16 <= r16_w;
          if (close) begin
            res   <= {gpsb_pkg::ST_CLOSE, 10'd0, r16_w, 1'b0};
            state <= S_DONE;
          end else if (f[39]) begin
            res   <= {gpsb_pkg::ST_ANGLE, 10'd0, r16_w, 1'b0};
            state <= S_DONE;
          end else begin
            res <= {gpsb_pkg::ST_DONE, 10'd0, r16_w, 1'b0};
            if (f == 40'sd0) begin
              bin_r <= (s > 40'sd0) ? 10'(NUM_BINS - 1) : 10'd0;
              state <= S_RD;
            end else if (t[26]) begin
              bin_r <= 10'd0;
              state <= S_RD;
            end else begin
              state <= S_MUL_T;
            end
          end
        end
        S_MUL_T: state <= S_BIN;
        S_BIN: begin
          bin_r <= (bq >= 16'(NUM_BINS)) ? 10'(NUM_BINS - 1) : bq[9:0];
          state <= S_RD;
        end
        S_RD: state <= S_UPD;
        S_UPD: begin
          if (item.action == gpsb_pkg::ACT_READ) begin
            res <= {gpsb_pkg::ST_DONE, bin_r, rd_data, 1'b0};
          end else begin
            res <= {gpsb_pkg::ST_DONE, bin_r, r16, (rd_data > r16)};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // busy right after taking a word
  `GPSB_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // no word is taken while the bins are being filled
  `GPSB_ASSERT_IMP(a_no_accept_in_sweep, state == S_SWEEP, !in_ready && mem_we)
  // a lowered bin is only ever reported with done status
  `GPSB_ASSERT_IMP(a_updated_done, out_valid && out_data.updated,
                   out_data.status == gpsb_pkg::ST_DONE)

endmodule
